### sv/hsfu_pkg.sv
// Shared constants and types for the Horn-Schunck flow update core.
// No dependencies; used by every module of the core.
`default_nettype none
package hsfu_pkg;
  localparam int FRAC_BITS_DEF = 8;
  localparam logic [15:0] WEIGHT_RST = 16'd256;
  localparam int QUOT_BITS = 17;
  localparam int PROD_W = 48;
  localparam int DEN_W = 34;
  localparam int FRONT_LAT = 3;
  localparam int LANE_LAT = QUOT_BITS + 2;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_u;
    logic signed [PROD_W-1:0] prod_v;
    logic [DEN_W-1:0] den;
    logic den_zero;
    logic signed [15:0] avg_u;
    logic signed [15:0] avg_v;
  } front_t;
endpackage
`default_nettype wire

### sv/horn_schunck_flow_update_core.sv
// Top level of the Horn-Schunck flow update core: weight register, valid
// line and stall control. Depends on hsfu_pkg, hsfu_front and hsfu_div.
//
//   channel | direction | handshake        | beat
//   in_     | input     | valid / stall    | avg_u avg_v grad_x grad_y grad_t last_pixel
//   out_    | output    | valid / stall    | new_u new_v clipped frame_end
//   cfg_    | input     | valid / ready    | reg_weight
//
// One beat enters per cycle while in_stall is low.
// Each lane holds 17 one-bit division stages.
// Reset clears the valid line and loads the weight with 256.
// An output stall with out_valid high freezes the whole pipeline; in_stall follows it.
`default_nettype none
module horn_schunck_flow_update_core #(
  parameter int FRAC_BITS = hsfu_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] in_avg_u,
  input  wire logic signed [15:0] in_avg_v,
  input  wire logic signed [15:0] in_grad_x,
  input  wire logic signed [15:0] in_grad_y,
  input  wire logic signed [15:0] in_grad_t,
  input  wire logic in_last_pixel,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] out_new_u,
  output logic signed [15:0] out_new_v,
  output logic out_clipped,
  output logic out_frame_end,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [15:0] cfg_reg_weight
);
  localparam int LAT = hsfu_pkg::FRONT_LAT + hsfu_pkg::LANE_LAT;

  logic ce;
  logic [15:0] weight_r;
  logic [LAT-1:0] vld_r, last_r;
  hsfu_pkg::front_t front;
  logic clip_u, clip_v;

  assign ce = !vld_r[LAT-1] || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= hsfu_pkg::WEIGHT_RST;
      vld_r <= '0;
    end else begin
      if (cfg_valid) begin
        weight_r <= cfg_reg_weight;
      end
      if (ce) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      last_r <= {last_r[LAT-2:0], in_last_pixel};
    end
  end

  hsfu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .ce(ce), .weight(weight_r),
    .avg_u(in_avg_u), .avg_v(in_avg_v), .grad_x(in_grad_x),
    .grad_y(in_grad_y), .grad_t(in_grad_t), .front(front)
  );

  hsfu_div u_div_u (
    .clk(clk), .ce(ce), .prod(front.prod_u), .den(front.den),
    .den_zero(front.den_zero), .base(front.avg_u), .res(out_new_u), .clip(clip_u)
  );

  hsfu_div u_div_v (
    .clk(clk), .ce(ce), .prod(front.prod_v), .den(front.den),
    .den_zero(front.den_zero), .base(front.avg_v), .res(out_new_v), .clip(clip_v)
  );

  assign in_stall = !ce;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];
  assign out_clipped = clip_u | clip_v;
  assign out_frame_end = last_r[LAT-1];
endmodule
`default_nettype wire

### sv/hsfu_front.sv
// Front stages: products, numerator and denominator, scaled numerators.
// Depends on hsfu_pkg.
`default_nettype none
module hsfu_front #(
  parameter int FRAC_BITS = hsfu_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic ce,
  input  wire logic [15:0] weight,
  input  wire logic signed [15:0] avg_u,
  input  wire logic signed [15:0] avg_v,
  input  wire logic signed [15:0] grad_x,
  input  wire logic signed [15:0] grad_y,
  input  wire logic signed [15:0] grad_t,
  output hsfu_pkg::front_t front
);
  logic signed [31:0] pxu_r, pyv_r, pxx_r, pyy_r;
  logic [31:0] paa_r;
  logic signed [15:0] gx1_r, gy1_r, gt1_r, u1_r, v1_r;
  logic signed [32:0] num_r;
  logic [hsfu_pkg::DEN_W-1:0] den_r;
  logic signed [15:0] gx2_r, gy2_r, u2_r, v2_r;
  logic signed [32:0] num_nxt;
  logic [hsfu_pkg::DEN_W-1:0] den_nxt;
  logic signed [48:0] mu_full, mv_full;
  hsfu_pkg::front_t front_r;

  always_comb begin
    num_nxt = ($signed({{17{gt1_r[15]}}, gt1_r}) <<< FRAC_BITS)
              + 33'(pxu_r) + 33'(pyv_r);
    den_nxt = hsfu_pkg::DEN_W'(paa_r) + hsfu_pkg::DEN_W'(pxx_r[30:0])
              + hsfu_pkg::DEN_W'(pyy_r[30:0]);
    mu_full = gx2_r * num_r;
    mv_full = gy2_r * num_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pxu_r <= grad_x * avg_u;
      pyv_r <= grad_y * avg_v;
      pxx_r <= grad_x * grad_x;
      pyy_r <= grad_y * grad_y;
      paa_r <= weight * weight;
      gx1_r <= grad_x;
      gy1_r <= grad_y;
      gt1_r <= grad_t;
      u1_r <= avg_u;
      v1_r <= avg_v;
      num_r <= num_nxt;
      den_r <= den_nxt;
      gx2_r <= gx1_r;
      gy2_r <= gy1_r;
      u2_r <= u1_r;
      v2_r <= v1_r;
      front_r.prod_u <= mu_full[hsfu_pkg::PROD_W-1:0];
      front_r.prod_v <= mv_full[hsfu_pkg::PROD_W-1:0];
      front_r.den <= den_r;
      front_r.den_zero <= (den_r == '0);
      front_r.avg_u <= u2_r;
      front_r.avg_v <= v2_r;
    end
  end

  assign front = front_r;
endmodule
`default_nettype wire

### sv/hsfu_div.sv
// One correction lane: rounded restoring division, one quotient bit per
// stage, then subtract from the average and saturate. Depends on hsfu_pkg.
`default_nettype none
module hsfu_div (
  input  wire logic clk,
  input  wire logic ce,
  input  wire logic signed [hsfu_pkg::PROD_W-1:0] prod,
  input  wire logic [hsfu_pkg::DEN_W-1:0] den,
  input  wire logic den_zero,
  input  wire logic signed [15:0] base,
  output logic signed [15:0] res,
  output logic clip
);
  localparam int QB = hsfu_pkg::QUOT_BITS;
  localparam int DW = hsfu_pkg::DEN_W;
  localparam int RW = hsfu_pkg::PROD_W + 1;
  localparam int CW = DW + QB;

  logic [RW-1:0] rem_r [QB+1];
  logic [QB-1:0] q_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic neg_r [QB+1];
  logic over_r [QB+1];
  logic zero_r [QB+1];
  logic signed [15:0] base_r [QB+1];
  logic [hsfu_pkg::PROD_W-1:0] mag;
  logic [RW-1:0] rem0_nxt;
  logic [QB:0] qs;
  logic signed [19:0] qx, bx, diff;
  logic signed [15:0] res_r, res_nxt;
  logic clip_r, clip_nxt;

  always_comb begin
    mag = prod[hsfu_pkg::PROD_W-1] ? hsfu_pkg::PROD_W'(-prod) : prod;
    rem0_nxt = RW'(mag) + RW'(den >> 1);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= rem0_nxt;
      q_r[0] <= '0;
      den_r[0] <= den;
      neg_r[0] <= prod[hsfu_pkg::PROD_W-1];
      over_r[0] <= CW'(rem0_nxt) >= (CW'(den) << QB);
      zero_r[0] <= den_zero;
      base_r[0] <= base;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [CW-1:0] dsh;
    logic ge;
    always_comb begin
      dsh = CW'(den_r[k-1]) << (QB - k);
      ge = CW'(rem_r[k-1]) >= dsh;
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k] <= ge ? RW'(CW'(rem_r[k-1]) - dsh) : rem_r[k-1];
        q_r[k] <= q_r[k-1] | (QB'(ge) << (QB - k));
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
        over_r[k] <= over_r[k-1];
        zero_r[k] <= zero_r[k-1];
        base_r[k] <= base_r[k-1];
      end
    end
  end

  always_comb begin
    qs = over_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_r[QB]};
    qx = $signed(20'(qs));
    bx = 20'(base_r[QB]);
    diff = neg_r[QB] ? bx + qx : bx - qx;
    clip_nxt = 1'b0;
    if (zero_r[QB]) begin
      res_nxt = base_r[QB];
      clip_nxt = 1'b1;
    end else if (diff > 20'sd32767) begin
      res_nxt = 16'sh7fff;
      clip_nxt = 1'b1;
    end else if (diff < -20'sd32768) begin
      res_nxt = 16'sh8000;
      clip_nxt = 1'b1;
    end else begin
      res_nxt = diff[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign res = res_r;
  assign clip = clip_r;
endmodule
`default_nettype wire

### sv/hsfu_checker.sv
// Port-level checks for horn_schunck_flow_update_core, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module hsfu_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic signed [15:0] out_new_u,
  input wire logic signed [15:0] out_new_v
);
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("out beat dropped");
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_new_u) && $stable(out_new_v))
    else $error("stalled out beat changed");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall) else $error("input stalled without cause");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("out beat after reset");
endmodule

bind horn_schunck_flow_update_core hsfu_checker u_hsfu_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_new_u(out_new_u), .out_new_v(out_new_v)
);
`default_nettype wire

### sim/horn_schunck_flow_update_core_test.sv
// Self-checking bench for horn_schunck_flow_update_core: a directed table, then random
// pixels. Each result is compared field by field against a local flow-update predictor.
// Depends on hsfu_pkg and the core RTL.
`timescale 1ns / 100ps
module horn_schunck_flow_update_core_test;
  localparam int FB = hsfu_pkg::FRAC_BITS_DEF;
  localparam int LAT = hsfu_pkg::FRONT_LAT + hsfu_pkg::LANE_LAT;

  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gt;
    logic last;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic clip;
    logic fend;
  } flow_t;

  typedef struct {
    pixel_t px;
    bit known;
    flow_t res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_avg_u = 0, in_avg_v = 0, in_grad_x = 0, in_grad_y = 0;
  logic signed [15:0] in_grad_t = 0;
  logic in_last_pixel = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_new_u, out_new_v;
  logic out_clipped, out_frame_end;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_reg_weight = 0;

  horn_schunck_flow_update_core i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  logic [15:0] weight;
  flow_t flow_q[$];
  int errors = 0;
  int n_px = 0;
  int n_res = 0;
  int n_clip = 0;

  function automatic longint round_div(longint p, longint d);
    longint mag;
    longint q;
    mag = p < 0 ? -p : p;
    q = (mag + d / 2) / d;
    return p < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint x, ref logic clip);
    if (x > 32767) begin
      clip = 1;
      return 16'sh7fff;
    end
    if (x < -32768) begin
      clip = 1;
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  function automatic flow_t update_flow(pixel_t p, logic [15:0] w);
    flow_t r;
    longint num;
    longint den;
    longint a;
    logic c;
    c = 0;
    a = w;
    num = longint'(p.gt) * (64'sd1 <<< FB) + longint'(p.gx) * p.u + longint'(p.gy) * p.v;
    den = a * a + longint'(p.gx) * p.gx + longint'(p.gy) * p.gy;
    if (den == 0) begin
      r.u = p.u;
      r.v = p.v;
      c = 1;
    end else begin
      r.u = clamp16(longint'(p.u) - round_div(longint'(p.gx) * num, den), c);
      r.v = clamp16(longint'(p.v) - round_div(longint'(p.gy) * num, den), c);
    end
    r.clip = c;
    r.fend = p.last;
    return r;
  endfunction

  function automatic int idle_draw();
    return $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 14));
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s at result %0d: got %0d, want %0d", what, n_res, got, want);
  endtask

  task automatic send_pixel(pixel_t p, bit known = 0, flow_t want = '0);
    flow_t r;
    int n_idle;
    r = update_flow(p, weight);
    n_idle = idle_draw();
    if (known && r !== want) begin
      report("directed row vs predictor", int'(r.u), int'(want.u));
    end
    if (n_idle > 0) begin
      in_valid <= 0;
      repeat (n_idle) @(posedge clk);
    end
    in_valid <= 1;
    {in_avg_u, in_avg_v, in_grad_x, in_grad_y, in_grad_t, in_last_pixel} <= p;
    flow_q.push_back(known ? want : r);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_px++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (flow_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic set_weight(logic [15:0] w);
    cfg_valid <= 1;
    cfg_reg_weight <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    weight = w;
  endtask

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 1024)) - 512);
      3: return 0;
      default: return 16'($urandom);
    endcase
  endfunction

  // output side: stall draws, compare each beat
  initial begin
    flow_t e;
    int wait_n;
    wait_n = idle_draw();
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        n_res++;
        if (flow_q.size() == 0) begin
          report("unexpected result beat", n_res, 0);
        end else begin
          e = flow_q.pop_front();
          if (out_new_u !== e.u) report("new_u", int'(out_new_u), int'(e.u));
          if (out_new_v !== e.v) report("new_v", int'(out_new_v), int'(e.v));
          if (out_clipped !== e.clip) report("clipped", int'(out_clipped), int'(e.clip));
          if (out_frame_end !== e.fend) begin
            report("frame_end", int'(out_frame_end), int'(e.fend));
          end
          if (e.clip) n_clip++;
        end
        wait_n = idle_draw();
      end
      if (wait_n > 0) begin
        out_stall <= 1;
        wait_n--;
      end else begin
        out_stall <= 0;
      end
    end
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    row_t tbl[$];
    logic [15:0] wts[5];
    pixel_t p;
    tbl.push_back('{'{16'sd100, -16'sd200, 0, 0, 16'sd50, 1'b0}, 1,
                    '{16'sd100, -16'sd200, 1'b0, 1'b0}});
    tbl.push_back('{'{16'sh7fff, 16'sh8000, 0, 0, 16'sh7fff, 1'b1}, 1,
                    '{16'sh7fff, 16'sh8000, 1'b0, 1'b1}});
    tbl.push_back('{'{16'sd256, 16'sd256, 16'sd256, 0, 0, 1'b0}, 0, '0});
    tbl.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1}, 0, '0});
    tbl.push_back('{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0}, 0, '0});
    tbl.push_back('{'{0, 0, 16'sd1, 16'sd1, 16'sh7fff, 1'b0}, 0, '0});
    tbl.push_back('{'{16'sh7fff, 0, 16'sd1, 0, 16'sh8000, 1'b0}, 0, '0});
    tbl.push_back('{'{-16'sd5, 16'sd7, -16'sd300, 16'sd40, -16'sd12, 1'b1}, 0, '0});
    tbl.push_back('{'{-16'sd1, -16'sd1, 16'sd3, 16'sd3, 16'sd1, 1'b0}, 0, '0});
    wts = '{16'd0, 16'hffff, 16'd1, 16'd256, 16'd16};

    weight = hsfu_pkg::WEIGHT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (tbl[i]) send_pixel(tbl[i].px, tbl[i].known, tbl[i].res);
    drain();

    // zero weight: zero gradients give a zero denominator
    set_weight(16'd0);
    send_pixel('{16'sh7fff, 16'sh8000, 0, 0, 16'sd9, 1'b1}, 1, '{16'sh7fff, 16'sh8000, 1'b1, 1'b1});
    send_pixel('{16'sd3, -16'sd4, 0, 0, 16'sh8000, 1'b0}, 1, '{16'sd3, -16'sd4, 1'b1, 1'b0});
    foreach (tbl[i]) send_pixel(tbl[i].px);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_weight(ph < 5 ? wts[ph] : 16'($urandom));
      for (int k = 0; k < 165; k++) begin
        p = {rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), 1'($urandom)};
        if ($urandom_range(0, 9) == 0) begin
          p.gx = 0;
          p.gy = 0;
        end
        send_pixel(p);
      end
      drain();
    end

    $display("%0d pixels sent, %0d results checked, %0d clipped, over several weights",
             n_px, n_res, n_clip);
    if (errors == 0 && flow_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
